### src/sos_pkg.sv
// Shared types, constants and helpers for the sweep obstacle segmenter.
package sos_pkg;

    localparam int ANGLE_W = 8;
    localparam int READ_W  = 10;
    localparam int SUM_W   = 12;
    localparam int AVG_W   = 14;
    localparam int DIST_W  = 9;
    localparam int NUM_W   = 6;
    localparam int TURN_W  = 7;
    localparam int FWD_W   = 13;
    localparam int CFG_W   = 10;
    localparam int MINW_W  = 8;

    localparam int SOS_FIFO_DEPTH = 4;

    localparam logic [CFG_W-1:0]  EDGE_THRESHOLD_RESET = 10'd30;
    localparam logic [MINW_W-1:0] MIN_WIDTH_RESET      = 8'd20;
    localparam logic [AVG_W-1:0]  PREV_AVG_RESET       = 14'd1600;
    localparam logic [DIST_W-1:0] DIST_NONE            = 9'd500;
    localparam logic [NUM_W-1:0]  KEPT_MAX             = 6'd63;
    localparam logic [ANGLE_W-1:0] ANGLE_MAX           = 8'd255;
    localparam logic [ANGLE_W-1:0] ANGLE_AHEAD         = 8'd90;
    localparam logic [TURN_W-1:0] TURN_MAX             = 7'd127;
    localparam logic [DIST_W-1:0] SENSOR_OFFSET        = 9'd4;
    localparam logic [15:0]       DIV3_RECIP           = 16'hAAAB;

    typedef enum logic
    {
        CFG_EDGE_THRESHOLD = 1'b0,
        CFG_MIN_WIDTH      = 1'b1
    } cfg_index_t;

    typedef enum logic
    {
        KIND_RECORD = 1'b0,
        KIND_FINAL  = 1'b1
    } kind_t;

    typedef struct packed
    {
        logic [ANGLE_W-1:0] angle;
        logic [READ_W-1:0]  reading_a;
        logic [READ_W-1:0]  reading_b;
        logic [READ_W-1:0]  reading_c;
        logic               sweep_end;
    } item_t;

    typedef struct packed
    {
        logic               kind;
        logic [NUM_W-1:0]   obstacle_number;
        logic [ANGLE_W-1:0] start_angle;
        logic [ANGLE_W-1:0] end_angle;
        logic [ANGLE_W-1:0] width_deg;
        logic [ANGLE_W-1:0] center_angle;
        logic [DIST_W-1:0]  distance_cm;
        logic               kept;
        logic               found;
        logic               steer_left;
        logic [TURN_W-1:0]  turn_deg;
        logic [FWD_W-1:0]   forward_mm;
    } res_t;

    function automatic logic [15:0] div3(input logic [15:0] x);
        logic [31:0] p;
        begin
            p = 32'(x) * 32'(DIV3_RECIP);
            return {1'b0, p[31:17]};
        end
    endfunction

endpackage

### src/sweep_obstacle_segmenter.sv
// Top level of the sweep obstacle segmenter: input register, config registers, result queue.
//
//  Channel  | Handshake            | Payload
//  ---------+----------------------+------------------------------------------------
//  in       | in_valid / in_stall  | angle, reading_a/b/c, sweep_end
//  out      | out_valid / out_stall| kind, obstacle_number ... forward_mm
//  cfg      | cfg_we               | cfg_index, cfg_data
//
// One sweep step per cycle while in_stall is low: a transaction lands in the input register,
// is processed when the queue has room for two, and its zero, one or two results enter it.
// The input stalls only while the result queue lacks room for two results.
// rst_n clears the sweep state, the queue and sets config to 30 cm / 20 degrees.
// Results leave in order, one per cycle when out_stall is low; the first result of a
// transaction reaches the outputs once it has been processed and written into the queue.
module sweep_obstacle_segmenter #(
    parameter int FifoDepth = sos_pkg::SOS_FIFO_DEPTH
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic                         cfg_index,
    input  logic [sos_pkg::CFG_W-1:0]    cfg_data,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [sos_pkg::ANGLE_W-1:0]  angle,
    input  logic [sos_pkg::READ_W-1:0]   reading_a,
    input  logic [sos_pkg::READ_W-1:0]   reading_b,
    input  logic [sos_pkg::READ_W-1:0]   reading_c,
    input  logic                         sweep_end,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic                         kind,
    output logic [sos_pkg::NUM_W-1:0]    obstacle_number,
    output logic [sos_pkg::ANGLE_W-1:0]  start_angle,
    output logic [sos_pkg::ANGLE_W-1:0]  end_angle,
    output logic [sos_pkg::ANGLE_W-1:0]  width_deg,
    output logic [sos_pkg::ANGLE_W-1:0]  center_angle,
    output logic [sos_pkg::DIST_W-1:0]   distance_cm,
    output logic                         kept,
    output logic                         found,
    output logic                         steer_left,
    output logic [sos_pkg::TURN_W-1:0]   turn_deg,
    output logic [sos_pkg::FWD_W-1:0]    forward_mm
);

    logic [sos_pkg::CFG_W-1:0]  edge_threshold_reg;
    logic [sos_pkg::MINW_W-1:0] min_width_reg;

    logic           item_valid_reg;
    sos_pkg::item_t item_reg;

    logic           in_accept;
    logic           fire;
    logic           room_for_two;
    logic           pop;
    logic [1:0]     res_num;
    logic [1:0]     push_num;
    sos_pkg::res_t  res_first;
    sos_pkg::res_t  res_second;
    sos_pkg::res_t  head;

    assign fire      = item_valid_reg && room_for_two;
    assign in_stall  = item_valid_reg && !room_for_two;
    assign in_accept = in_valid && !in_stall;
    assign push_num  = fire ? res_num : 2'd0;
    assign pop       = out_valid && !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            edge_threshold_reg <= sos_pkg::EDGE_THRESHOLD_RESET;
            min_width_reg      <= sos_pkg::MIN_WIDTH_RESET;
        end
        else if (cfg_we)
        begin
            unique case (sos_pkg::cfg_index_t'(cfg_index))
                sos_pkg::CFG_EDGE_THRESHOLD: edge_threshold_reg <= cfg_data;
                sos_pkg::CFG_MIN_WIDTH:      min_width_reg <= cfg_data[sos_pkg::MINW_W-1:0];
                default:                     ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            item_valid_reg <= 1'b1;
        end
        else if (fire)
        begin
            item_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            item_reg.angle     <= angle;
            item_reg.reading_a <= reading_a;
            item_reg.reading_b <= reading_b;
            item_reg.reading_c <= reading_c;
            item_reg.sweep_end <= sweep_end;
        end
    end

    sos_core u_core (
        .clk            (clk),
        .rst_n          (rst_n),
        .fire           (fire),
        .item           (item_reg),
        .edge_threshold (edge_threshold_reg),
        .min_width      (min_width_reg),
        .res_num        (res_num),
        .res_first      (res_first),
        .res_second     (res_second)
    );

    sos_fifo #(
        .Depth (FifoDepth)
    ) u_fifo (
        .clk          (clk),
        .rst_n        (rst_n),
        .push_num     (push_num),
        .push_first   (res_first),
        .push_second  (res_second),
        .pop          (pop),
        .head         (head),
        .not_empty    (out_valid),
        .room_for_two (room_for_two)
    );

    assign kind            = head.kind;
    assign obstacle_number = head.obstacle_number;
    assign start_angle     = head.start_angle;
    assign end_angle       = head.end_angle;
    assign width_deg       = head.width_deg;
    assign center_angle    = head.center_angle;
    assign distance_cm     = head.distance_cm;
    assign kept            = head.kept;
    assign found           = head.found;
    assign steer_left      = head.steer_left;
    assign turn_deg        = head.turn_deg;
    assign forward_mm      = head.forward_mm;

endmodule

### src/sos_fifo.sv
// Result queue with two write slots per cycle and one read port.
module sos_fifo #(
    parameter int Depth = sos_pkg::SOS_FIFO_DEPTH
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic [1:0]        push_num,
    input  sos_pkg::res_t     push_first,
    input  sos_pkg::res_t     push_second,
    input  logic              pop,
    output sos_pkg::res_t     head,
    output logic              not_empty,
    output logic              room_for_two
);

    localparam int PtrW = $clog2(Depth);
    localparam int CntW = $clog2(Depth + 1);
    localparam logic [CntW-1:0] RoomLimit = CntW'(Depth - 2);

    sos_pkg::res_t mem [Depth];

    logic [PtrW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0] count_reg, count_next;
    logic [PtrW-1:0] wr_ptr_second;

    assign wr_ptr_second = wr_ptr_reg + PtrW'(1);
    assign head          = mem[rd_ptr_reg];
    assign not_empty     = count_reg != '0;
    assign room_for_two  = count_reg <= RoomLimit;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + PtrW'(push_num);
        rd_ptr_next = rd_ptr_reg + PtrW'(pop);
        count_next  = count_reg + CntW'(push_num) - CntW'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push_num != 2'd0)
        begin
            mem[wr_ptr_reg] <= push_first;
        end
        if (push_num == 2'd2)
        begin
            mem[wr_ptr_second] <= push_second;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

### src/sos_core.sv
// Per-step edge detection, obstacle tracking and final selection with sweep state.
module sos_core (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        fire,
    input  sos_pkg::item_t              item,
    input  logic [sos_pkg::CFG_W-1:0]   edge_threshold,
    input  logic [sos_pkg::MINW_W-1:0]  min_width,
    output logic [1:0]                  res_num,
    output sos_pkg::res_t               res_first,
    output sos_pkg::res_t               res_second
);

    logic [sos_pkg::AVG_W-1:0]   prev_avg_reg, prev_avg_next;
    logic                        open_reg, open_next;
    logic [sos_pkg::ANGLE_W-1:0] open_start_reg, open_start_next;
    logic [sos_pkg::DIST_W-1:0]  run_min_reg, run_min_next;
    logic [sos_pkg::NUM_W-1:0]   kept_count_reg, kept_count_next;
    logic [sos_pkg::ANGLE_W-1:0] best_width_reg, best_width_next;
    logic [sos_pkg::ANGLE_W-1:0] best_center_reg, best_center_next;
    logic [sos_pkg::DIST_W-1:0]  best_dist_reg, best_dist_next;

    logic [sos_pkg::SUM_W-1:0]   sum;
    logic [15:0]                 avg_full;
    logic [15:0]                 cm_full;
    logic [sos_pkg::AVG_W-1:0]   avg;
    logic [sos_pkg::READ_W-1:0]  cm;
    logic [sos_pkg::AVG_W-1:0]   thr;
    logic [sos_pkg::DIST_W-1:0]  run_min_upd;
    logic                        drop;
    logic                        rise;
    logic                        open_now;
    logic [sos_pkg::ANGLE_W-1:0] start_now;
    logic                        close_rise;
    logic                        close_end;
    logic                        close;
    logic [sos_pkg::ANGLE_W-1:0] end_ang;
    logic [sos_pkg::ANGLE_W-1:0] width;
    logic [sos_pkg::ANGLE_W-1:0] center;
    logic                        keep;
    logic                        better;
    logic [sos_pkg::NUM_W-1:0]   kept_after;
    logic [sos_pkg::ANGLE_W-1:0] bw_after;
    logic [sos_pkg::ANGLE_W-1:0] bc_after;
    logic [sos_pkg::DIST_W-1:0]  bd_after;
    logic [sos_pkg::ANGLE_W-1:0] turn_diff;
    logic [sos_pkg::DIST_W-1:0]  dist_off;
    sos_pkg::res_t               rec;
    sos_pkg::res_t               fin;

    assign sum = sos_pkg::SUM_W'(item.reading_a) + sos_pkg::SUM_W'(item.reading_b)
               + sos_pkg::SUM_W'(item.reading_c);
    assign avg_full = sos_pkg::div3({sum, 4'b0000});
    assign cm_full  = sos_pkg::div3({4'b0000, sum});
    assign avg      = avg_full[sos_pkg::AVG_W-1:0];
    assign cm       = cm_full[sos_pkg::READ_W-1:0];
    assign thr      = {edge_threshold, 4'b0000};

    always_comb
    begin
        run_min_upd = run_min_reg;
        if (open_reg && ({1'b0, run_min_reg} > cm))
        begin
            run_min_upd = cm[sos_pkg::DIST_W-1:0];
        end

        drop = (prev_avg_reg != '0) && (prev_avg_reg > avg) && ((prev_avg_reg - avg) > thr);
        rise = (prev_avg_reg != '0) && (avg > prev_avg_reg) && ((avg - prev_avg_reg) > thr);

        open_now  = open_reg || drop;
        start_now = (!open_reg && drop) ? item.angle : open_start_reg;

        close_rise = open_now && rise;
        close_end  = item.sweep_end && open_now && !rise;
        close      = close_rise || close_end;

        if (close_rise)
        begin
            end_ang = item.angle;
        end
        else if (item.angle == sos_pkg::ANGLE_MAX)
        begin
            end_ang = sos_pkg::ANGLE_MAX;
        end
        else
        begin
            end_ang = item.angle + 8'd1;
        end

        width  = (end_ang >= start_now) ? (end_ang - start_now) : '0;
        center = start_now + (width >> 1);
        keep   = width >= min_width;

        better     = close && keep && ((kept_count_reg == '0) || (width < best_width_reg));
        bw_after   = better ? width : best_width_reg;
        bc_after   = better ? center : best_center_reg;
        bd_after   = better ? run_min_upd : best_dist_reg;
        kept_after = (close && keep && (kept_count_reg < sos_pkg::KEPT_MAX))
                   ? kept_count_reg + 6'd1 : kept_count_reg;

        rec                 = '0;
        rec.kind            = sos_pkg::KIND_RECORD;
        rec.obstacle_number = kept_count_reg;
        rec.start_angle     = start_now;
        rec.end_angle       = end_ang;
        rec.width_deg       = width;
        rec.center_angle    = center;
        rec.distance_cm     = run_min_upd;
        rec.kept            = keep;

        fin       = '0;
        fin.kind  = sos_pkg::KIND_FINAL;
        turn_diff = '0;
        dist_off  = bd_after - sos_pkg::SENSOR_OFFSET;
        if (kept_after != '0)
        begin
            fin.width_deg    = bw_after;
            fin.center_angle = bc_after;
            fin.distance_cm  = bd_after;
            fin.found        = 1'b1;
            if (bc_after > sos_pkg::ANGLE_AHEAD)
            begin
                fin.steer_left = 1'b1;
                turn_diff      = bc_after - sos_pkg::ANGLE_AHEAD;
            end
            else
            begin
                turn_diff = sos_pkg::ANGLE_AHEAD - bc_after;
            end
            fin.turn_deg = (turn_diff > 8'(sos_pkg::TURN_MAX))
                         ? sos_pkg::TURN_MAX : turn_diff[sos_pkg::TURN_W-1:0];
            if (bd_after > sos_pkg::SENSOR_OFFSET)
            begin
                fin.forward_mm = sos_pkg::FWD_W'({dist_off, 3'b000})
                               + sos_pkg::FWD_W'({dist_off, 1'b0});
            end
        end

        res_num    = 2'(close) + 2'(item.sweep_end);
        res_first  = close ? rec : fin;
        res_second = fin;

        if (item.sweep_end)
        begin
            prev_avg_next    = sos_pkg::PREV_AVG_RESET;
            open_next        = 1'b0;
            open_start_next  = '0;
            run_min_next     = sos_pkg::DIST_NONE;
            kept_count_next  = '0;
            best_width_next  = '0;
            best_center_next = '0;
            best_dist_next   = '0;
        end
        else
        begin
            prev_avg_next    = avg;
            open_next        = open_now && !close_rise;
            open_start_next  = start_now;
            run_min_next     = close ? sos_pkg::DIST_NONE : run_min_upd;
            kept_count_next  = kept_after;
            best_width_next  = bw_after;
            best_center_next = bc_after;
            best_dist_next   = bd_after;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_avg_reg    <= sos_pkg::PREV_AVG_RESET;
            open_reg        <= 1'b0;
            open_start_reg  <= '0;
            run_min_reg     <= sos_pkg::DIST_NONE;
            kept_count_reg  <= '0;
            best_width_reg  <= '0;
            best_center_reg <= '0;
            best_dist_reg   <= '0;
        end
        else if (fire)
        begin
            prev_avg_reg    <= prev_avg_next;
            open_reg        <= open_next;
            open_start_reg  <= open_start_next;
            run_min_reg     <= run_min_next;
            kept_count_reg  <= kept_count_next;
            best_width_reg  <= best_width_next;
            best_center_reg <= best_center_next;
            best_dist_reg   <= best_dist_next;
        end
    end

endmodule

### verif/sweep_obstacle_segmenter_tb.sv
// Self-checking testbench for the sweep obstacle segmenter: directed and random sweeps.
module sweep_obstacle_segmenter_tb;

    localparam int QUIET_LIMIT = 4000;
    localparam int IDLE_PCT    = 21;
    localparam int HOLD_CYCLES = 96;
    localparam int SETTLE      = 8;

    class obstacle_tracker;
        logic [sos_pkg::CFG_W-1:0]   edge_thr;
        logic [sos_pkg::MINW_W-1:0]  min_w;
        logic [sos_pkg::AVG_W-1:0]   prev_avg;
        bit                          is_open;
        logic [sos_pkg::ANGLE_W-1:0] start_ang;
        logic [sos_pkg::DIST_W-1:0]  run_min;
        logic [sos_pkg::NUM_W-1:0]   kept_cnt;
        logic [sos_pkg::ANGLE_W-1:0] best_w;
        logic [sos_pkg::ANGLE_W-1:0] best_c;
        logic [sos_pkg::DIST_W-1:0]  best_d;
        sos_pkg::res_t               expected_reports[$];
        int unsigned                 n_steps;
        int unsigned                 n_records;
        int unsigned                 n_finals;
        int unsigned                 n_settings;
        int unsigned                 mismatches;

        function new();
            edge_thr = sos_pkg::EDGE_THRESHOLD_RESET;
            min_w = sos_pkg::MIN_WIDTH_RESET;
            n_steps = 0;
            n_records = 0;
            n_finals = 0;
            n_settings = 1;
            mismatches = 0;
            clear_sweep();
        endfunction

        function void clear_sweep();
            prev_avg = sos_pkg::PREV_AVG_RESET;
            is_open = 1'b0;
            start_ang = '0;
            run_min = sos_pkg::DIST_NONE;
            kept_cnt = '0;
            best_w = '0;
            best_c = '0;
            best_d = '0;
        endfunction

        function void set_limits(input logic [sos_pkg::CFG_W-1:0] thr,
                                 input logic [sos_pkg::MINW_W-1:0] mw);
            edge_thr = thr;
            min_w = mw;
            n_settings++;
        endfunction

        function int pending();
            return expected_reports.size();
        endfunction

        function void close_at(input int unsigned end_ang);
            int unsigned w;
            int unsigned ctr;
            sos_pkg::res_t rec;
            w = (end_ang >= start_ang) ? end_ang - start_ang : 0;
            ctr = start_ang + w / 2;
            rec = '0;
            rec.kind = sos_pkg::KIND_RECORD;
            rec.obstacle_number = kept_cnt;
            rec.start_angle = start_ang;
            rec.end_angle = sos_pkg::ANGLE_W'(end_ang);
            rec.width_deg = sos_pkg::ANGLE_W'(w);
            rec.center_angle = sos_pkg::ANGLE_W'(ctr);
            rec.distance_cm = run_min;
            rec.kept = (w >= min_w);
            if (w >= min_w)
            begin
                if (kept_cnt == 0 || w < best_w)
                begin
                    best_w = sos_pkg::ANGLE_W'(w);
                    best_c = sos_pkg::ANGLE_W'(ctr);
                    best_d = run_min;
                end
                if (kept_cnt < sos_pkg::KEPT_MAX)
                    kept_cnt++;
            end
            expected_reports.push_back(rec);
            n_records++;
            is_open = 1'b0;
            run_min = sos_pkg::DIST_NONE;
        endfunction

        function void take_step(input sos_pkg::item_t it);
            int unsigned total;
            int unsigned avg16;
            int unsigned thr16;
            int unsigned prev;
            int unsigned td;
            sos_pkg::res_t fin;
            total = int'(it.reading_a) + int'(it.reading_b) + int'(it.reading_c);
            avg16 = total * 16 / 3;
            thr16 = int'(edge_thr) * 16;
            prev = prev_avg;
            n_steps++;
            if (is_open && 3 * int'(run_min) > total)
                run_min = sos_pkg::DIST_W'(total / 3);
            if (!is_open && prev != 0 && prev > avg16 && prev - avg16 > thr16)
            begin
                is_open = 1'b1;
                start_ang = it.angle;
            end
            if (is_open && prev != 0 && avg16 > prev && avg16 - prev > thr16)
                close_at(int'(it.angle));
            prev_avg = sos_pkg::AVG_W'(avg16);
            if (it.sweep_end)
            begin
                if (is_open)
                    close_at((it.angle < sos_pkg::ANGLE_MAX) ? int'(it.angle) + 1
                                                             : int'(sos_pkg::ANGLE_MAX));
                fin = '0;
                fin.kind = sos_pkg::KIND_FINAL;
                if (kept_cnt != 0)
                begin
                    fin.width_deg = best_w;
                    fin.center_angle = best_c;
                    fin.distance_cm = best_d;
                    fin.found = 1'b1;
                    if (best_c > sos_pkg::ANGLE_AHEAD)
                    begin
                        fin.steer_left = 1'b1;
                        td = int'(best_c) - int'(sos_pkg::ANGLE_AHEAD);
                    end
                    else
                        td = int'(sos_pkg::ANGLE_AHEAD) - int'(best_c);
                    fin.turn_deg = (td > sos_pkg::TURN_MAX) ? sos_pkg::TURN_MAX
                                                            : sos_pkg::TURN_W'(td);
                    if (best_d > sos_pkg::SENSOR_OFFSET)
                        fin.forward_mm = sos_pkg::FWD_W'(
                            (int'(best_d) - int'(sos_pkg::SENSOR_OFFSET)) * 10);
                end
                expected_reports.push_back(fin);
                n_finals++;
                clear_sweep();
            end
        endfunction

        function void compare_field(input string field, input logic [15:0] want,
                                    input logic [15:0] seen);
            if (seen !== want)
            begin
                $error("%s: expected %0d, got %0d", field, want, seen);
                mismatches++;
            end
        endfunction

        function void match_report(input sos_pkg::res_t got);
            sos_pkg::res_t want;
            if (expected_reports.size() == 0)
            begin
                $error("result with nothing pending: kind %0d start %0d end %0d",
                       got.kind, got.start_angle, got.end_angle);
                mismatches++;
                return;
            end
            want = expected_reports.pop_front();
            compare_field("kind", 16'(want.kind), 16'(got.kind));
            compare_field("obstacle_number", 16'(want.obstacle_number),
                          16'(got.obstacle_number));
            compare_field("start_angle", 16'(want.start_angle), 16'(got.start_angle));
            compare_field("end_angle", 16'(want.end_angle), 16'(got.end_angle));
            compare_field("width_deg", 16'(want.width_deg), 16'(got.width_deg));
            compare_field("center_angle", 16'(want.center_angle), 16'(got.center_angle));
            compare_field("distance_cm", 16'(want.distance_cm), 16'(got.distance_cm));
            compare_field("kept", 16'(want.kept), 16'(got.kept));
            compare_field("found", 16'(want.found), 16'(got.found));
            compare_field("steer_left", 16'(want.steer_left), 16'(got.steer_left));
            compare_field("turn_deg", 16'(want.turn_deg), 16'(got.turn_deg));
            compare_field("forward_mm", 16'(want.forward_mm), 16'(got.forward_mm));
        endfunction
    endclass

    logic                         clk = 1'b0;
    logic                         rst_n = 1'b0;
    logic                         cfg_we = 1'b0;
    logic                         cfg_index = sos_pkg::CFG_EDGE_THRESHOLD;
    logic [sos_pkg::CFG_W-1:0]    cfg_data = '0;
    logic                         in_valid = 1'b0;
    logic                         in_stall;
    logic [sos_pkg::ANGLE_W-1:0]  angle = '0;
    logic [sos_pkg::READ_W-1:0]   reading_a = '0;
    logic [sos_pkg::READ_W-1:0]   reading_b = '0;
    logic [sos_pkg::READ_W-1:0]   reading_c = '0;
    logic                         sweep_end = 1'b0;
    logic                         out_valid;
    logic                         out_stall = 1'b0;
    logic                         kind;
    logic [sos_pkg::NUM_W-1:0]    obstacle_number;
    logic [sos_pkg::ANGLE_W-1:0]  start_angle;
    logic [sos_pkg::ANGLE_W-1:0]  end_angle;
    logic [sos_pkg::ANGLE_W-1:0]  width_deg;
    logic [sos_pkg::ANGLE_W-1:0]  center_angle;
    logic [sos_pkg::DIST_W-1:0]   distance_cm;
    logic                         kept;
    logic                         found;
    logic                         steer_left;
    logic [sos_pkg::TURN_W-1:0]   turn_deg;
    logic [sos_pkg::FWD_W-1:0]    forward_mm;

    obstacle_tracker tracker;
    bit              calm = 1'b0;
    bit              hold_req = 1'b0;
    int unsigned     quiet = 0;
    int unsigned     hold_left = 0;

    sweep_obstacle_segmenter i_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .angle           (angle),
        .reading_a       (reading_a),
        .reading_b       (reading_b),
        .reading_c       (reading_c),
        .sweep_end       (sweep_end),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .kind            (kind),
        .obstacle_number (obstacle_number),
        .start_angle     (start_angle),
        .end_angle       (end_angle),
        .width_deg       (width_deg),
        .center_angle    (center_angle),
        .distance_cm     (distance_cm),
        .kept            (kept),
        .found           (found),
        .steer_left      (steer_left),
        .turn_deg        (turn_deg),
        .forward_mm      (forward_mm)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic send_step(input sos_pkg::item_t it);
        while (!calm && $urandom_range(0, 99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        angle <= it.angle;
        reading_a <= it.reading_a;
        reading_b <= it.reading_b;
        reading_c <= it.reading_c;
        sweep_end <= it.sweep_end;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        tracker.take_step(it);
    endtask

    task automatic step(input int ang, input int a, input int b, input int c, input bit last);
        sos_pkg::item_t it;
        it.angle = sos_pkg::ANGLE_W'(ang);
        it.reading_a = sos_pkg::READ_W'(a);
        it.reading_b = sos_pkg::READ_W'(b);
        it.reading_c = sos_pkg::READ_W'(c);
        it.sweep_end = last;
        send_step(it);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (tracker.pending() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_regs(input int thr, input int mw);
        cfg_we <= 1'b1;
        cfg_index <= sos_pkg::CFG_EDGE_THRESHOLD;
        cfg_data <= sos_pkg::CFG_W'(thr);
        @(posedge clk);
        cfg_index <= sos_pkg::CFG_MIN_WIDTH;
        cfg_data <= sos_pkg::CFG_W'(mw);
        @(posedge clk);
        cfg_we <= 1'b0;
        tracker.set_limits(sos_pkg::CFG_W'(thr), sos_pkg::MINW_W'(mw));
    endtask

    task automatic clean_sweep(input int unsigned thr_cm);
        int unsigned jump;
        int unsigned far_lvl;
        int unsigned near_lvl;
        int unsigned lvl;
        int unsigned ang;
        int unsigned n;
        bit          near_now;
        jump = thr_cm + 1 + $urandom_range(0, 12);
        if (jump > 1000)
        begin
            far_lvl = 1020;
            jump = 1000;
        end
        else
            far_lvl = $urandom_range(jump, 1020);
        near_lvl = $urandom_range(0, far_lvl - jump);
        near_now = 1'b0;
        ang = $urandom_range(0, 10);
        n = $urandom_range(3, 30);
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 4) == 0)
            begin
                near_now = !near_now;
                if (near_now)
                    near_lvl = $urandom_range(0, far_lvl - jump);
            end
            lvl = near_now ? near_lvl : far_lvl;
            step(ang, lvl + $urandom_range(0, 3), lvl + $urandom_range(0, 3),
                 lvl + $urandom_range(0, 3), i == n - 1);
            ang = ang + $urandom_range(1, 12);
            if (ang > 180)
                ang = 180;
        end
    endtask

    task automatic noise_sweep();
        int unsigned n;
        bit          dark;
        n = $urandom_range(1, 10);
        for (int i = 0; i < n; i++)
        begin
            dark = ($urandom_range(0, 5) == 0);
            step($urandom_range(0, 180),
                 dark ? 0 : $urandom_range(0, 1023),
                 dark ? 0 : $urandom_range(0, 1023),
                 dark ? 0 : $urandom_range(0, 1023),
                 i == n - 1);
        end
    endtask

    task automatic run_phase(input int thr, input int mw, input int count);
        int unsigned target;
        write_regs(thr, mw);
        target = tracker.n_steps + count;
        while (tracker.n_steps < target)
        begin
            if ($urandom_range(0, 9) < 8)
                clean_sweep(thr);
            else
                noise_sweep();
        end
        drain();
    endtask

    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
            begin
                sos_pkg::res_t got;
                got.kind = kind;
                got.obstacle_number = obstacle_number;
                got.start_angle = start_angle;
                got.end_angle = end_angle;
                got.width_deg = width_deg;
                got.center_angle = center_angle;
                got.distance_cm = distance_cm;
                got.kept = kept;
                got.found = found;
                got.steer_left = steer_left;
                got.turn_deg = turn_deg;
                got.forward_mm = forward_mm;
                tracker.match_report(got);
            end
            if (hold_req && hold_left == 0)
            begin
                hold_left = HOLD_CYCLES;
                hold_req = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
                out_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
        end
    end

    initial
    begin
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("sweep_obstacle_segmenter verification failed");
        $finish;
    end

    initial
    begin
        tracker = new();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // open on a drop, stay open through a zero average, close on a rise
        step(0, 0, 0, 0, 1'b0);
        step(5, 0, 0, 0, 1'b0);
        step(30, 1023, 1023, 1023, 1'b0);
        step(40, 100, 100, 100, 1'b0);
        step(50, 1023, 1023, 1023, 1'b0);
        step(60, 10, 10, 10, 1'b0);
        step(62, 20, 20, 20, 1'b0);
        step(70, 600, 600, 600, 1'b0);
        step(80, 10, 11, 12, 1'b0);
        step(75, 200, 200, 200, 1'b0);
        step(120, 50, 50, 50, 1'b1);
        // equal widths: the earlier obstacle wins, turn left
        step(95, 900, 900, 900, 1'b0);
        step(100, 400, 400, 400, 1'b0);
        step(120, 400, 401, 402, 1'b0);
        step(130, 1023, 1023, 1023, 1'b0);
        step(140, 500, 500, 500, 1'b0);
        step(170, 1000, 1000, 1000, 1'b0);
        step(180, 300, 300, 300, 1'b1);
        // nothing kept, end angle saturates
        step(254, 1023, 1023, 1023, 1'b0);
        step(255, 0, 0, 0, 1'b1);
        drain();

        write_regs(0, 0);
        step(240, 1023, 1023, 1023, 1'b0);
        step(250, 0, 0, 0, 1'b0);
        step(255, 0, 0, 0, 1'b1);
        drain();

        run_phase(30, 20, 170);
        calm = 1'b1;
        run_phase(0, 0, 170);
        calm = 1'b0;
        run_phase(1023, 180, 120);
        hold_req = 1'b1;
        run_phase(12, 5, 170);
        repeat (2) run_phase($urandom_range(0, 150), $urandom_range(0, 180), 150);

        $display("Ran %0d sweep steps under %0d register settings, with stalls and a long hold-off",
                 tracker.n_steps, tracker.n_settings);
        $display("Checked %0d obstacle records and %0d sweep selections",
                 tracker.n_records, tracker.n_finals);
        if (tracker.mismatches == 0 && tracker.pending() == 0)
            $display("sweep_obstacle_segmenter verification clean");
        else
            $display("sweep_obstacle_segmenter verification failed");
        $finish;
    end

endmodule
